// ----- rtl/pfla_pkg.sv -----
// package: sizes, codes and beat types of the page free-list allocator
`timescale 1ns / 1ps
package pfla_pkg;

    localparam int NUM_TABLES = 16;
    localparam int MAX_PAGES  = 4096;
    localparam int GROW_CHAIN = 100;

    localparam int TBL_W   = $clog2(NUM_TABLES);
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int COUNT_W = PAGE_W + 1;
    localparam int ADDR_W  = TBL_W + PAGE_W;
    localparam int STEP_W  = $clog2(GROW_CHAIN + 1);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_GROW,
        S_HOLD
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [TBL_W-1:0]  table_req;
        logic [PAGE_W-1:0] page;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        logic               head_we;
        logic               count_we;
        logic [TBL_W-1:0]   tbl;
        logic [PAGE_W-1:0]  head;
        logic [COUNT_W-1:0] count;
    } tbl_wr_t;

endpackage

// ----- rtl/pfla_link_ram.sv -----
// next-pointer store: one synchronous port, registered read data
`timescale 1ns / 1ps
module pfla_link_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [pfla_pkg::ADDR_W-1:0] addr,
    input  logic [pfla_pkg::PAGE_W-1:0] wdata,
    output logic [pfla_pkg::PAGE_W-1:0] rdata
);
    import pfla_pkg::*;

    logic [PAGE_W-1:0] mem [1 << ADDR_W];
    logic [PAGE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pfla_table_regs.sv -----
// per-table free-list head and page count registers
`timescale 1ns / 1ps
module pfla_table_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pfla_pkg::TBL_W-1:0]   rd_tbl,
    input  pfla_pkg::tbl_wr_t            wr,
    output logic [pfla_pkg::PAGE_W-1:0]  head,
    output logic [pfla_pkg::COUNT_W-1:0] count
);
    import pfla_pkg::*;

    logic [PAGE_W-1:0]  head_reg  [NUM_TABLES];
    logic [COUNT_W-1:0] count_reg [NUM_TABLES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= COUNT_W'(1);
            end
        end
        else
        begin
            if (wr.head_we)
            begin
                head_reg[wr.tbl] <= wr.head;
            end
            if (wr.count_we)
            begin
                count_reg[wr.tbl] <= wr.count;
            end
        end
    end

    assign head  = head_reg[rd_tbl];
    assign count = count_reg[rd_tbl];

endmodule

// ----- rtl/page_free_list_allocator.sv -----
// top level: request sequencer, chunk growth and output register
// free, format and unused op: result registered on accept, via the hold reg if stalled
// allocate from a non-empty list: waits in S_READ for the registered next-pointer read
// allocate that grows the table: S_GROW links a new chunk, one link written per cycle
// input ready again once the result is registered, so one request is taken at a time
// reset: heads 0, counts 1, next-pointer store not cleared, no init pass
`timescale 1ns / 1ps
module page_free_list_allocator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  pfla_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pfla_pkg::rsp_t  rsp
);
    import pfla_pkg::*;

    state_t             state_reg, state_next;
    logic [TBL_W-1:0]   tbl_reg, tbl_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    rsp_t               hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PAGE_W-1:0]  mem_wdata;
    logic [PAGE_W-1:0]  mem_rdata;

    logic [TBL_W-1:0]   rd_tbl;
    logic [PAGE_W-1:0]  cur_head;
    logic [COUNT_W-1:0] cur_count;
    tbl_wr_t            tbl_wr;

    logic               slot_free;
    logic               res_valid;
    rsp_t               res;
    logic               accept;
    logic               grow_fits;
    logic               bad_free;
    logic [PAGE_W-1:0]  grow_page;
    logic               grow_last;

    pfla_link_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pfla_table_regs u_tables (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_tbl (rd_tbl),
        .wr     (tbl_wr),
        .head   (cur_head),
        .count  (cur_count)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rd_tbl    = (state_reg == S_IDLE) ? req.table_req : tbl_reg;
    assign slot_free = !out_valid_reg || rsp_ready;

    assign grow_fits = ({1'b0, cur_count} + (COUNT_W + 1)'(GROW_CHAIN + 1))
                       <= (COUNT_W + 1)'(MAX_PAGES);
    assign bad_free  = (req.page == '0) || ({1'b0, req.page} >= cur_count);
    assign grow_page = page_reg + PAGE_W'(step_reg);
    assign grow_last = (step_reg == STEP_W'(GROW_CHAIN));

    always_comb
    begin
        state_next = state_reg;
        tbl_next   = tbl_reg;
        page_next  = page_reg;
        step_next  = step_reg;
        hold_next  = hold_reg;
        mem_we     = 1'b0;
        mem_addr   = {req.table_req, cur_head};
        mem_wdata  = cur_head;
        tbl_wr     = '0;
        tbl_wr.tbl = rd_tbl;
        res_valid  = 1'b0;
        res        = '{page_number: '0, status: ST_OK};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tbl_next = req.table_req;
                    unique case (req.op)
                        OP_ALLOC:
                        begin
                            if (cur_head != '0)
                            begin
                                page_next  = cur_head;
                                state_next = S_READ;
                            end
                            else if (grow_fits)
                            begin
                                page_next  = cur_count[PAGE_W-1:0];
                                step_next  = '0;
                                state_next = S_GROW;
                            end
                            else
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_FULL;
                            end
                        end
                        OP_FREE:
                        begin
                            res_valid = 1'b1;
                            if (bad_free)
                            begin
                                res.status = ST_BAD;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_addr       = {req.table_req, req.page};
                                mem_wdata      = cur_head;
                                tbl_wr.head_we = 1'b1;
                                tbl_wr.head    = req.page;
                            end
                        end
                        OP_FORMAT:
                        begin
                            res_valid       = 1'b1;
                            tbl_wr.head_we  = 1'b1;
                            tbl_wr.count_we = 1'b1;
                            tbl_wr.head     = '0;
                            tbl_wr.count    = COUNT_W'(1);
                        end
                        OP_NOP:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_valid       = 1'b1;
                res.page_number = page_reg;
                tbl_wr.head_we  = 1'b1;
                tbl_wr.head     = mem_rdata;
                state_next      = S_IDLE;
            end
            S_GROW:
            begin
                mem_we    = 1'b1;
                mem_addr  = {tbl_reg, grow_page};
                mem_wdata = grow_last ? '0 : grow_page + PAGE_W'(1);
                step_next = step_reg + STEP_W'(1);
                if (grow_last)
                begin
                    // chunk head is handed out, its successor becomes the head
                    res_valid       = 1'b1;
                    res.page_number = page_reg;
                    tbl_wr.head_we  = 1'b1;
                    tbl_wr.count_we = 1'b1;
                    tbl_wr.head     = page_reg + PAGE_W'(1);
                    tbl_wr.count    = {1'b0, page_reg} + COUNT_W'(GROW_CHAIN + 1);
                    state_next      = S_IDLE;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_valid && !slot_free)
        begin
            hold_next  = res;
            state_next = S_HOLD;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        if (state_reg == S_HOLD && slot_free)
        begin
            out_next       = hold_reg;
            out_valid_next = 1'b1;
        end
        else if (res_valid && slot_free)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg  <= tbl_next;
        page_reg <= page_next;
        step_reg <= step_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
